@@ src/hxu8c_pkg.sv @@
package hxu8c_pkg;

    // Field widths fixed by the stream format
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 3;
    localparam int CFG_DATA_W = 11;
    localparam int COL_OUT_W  = 10;
    localparam int OFF_OUT_W  = 32;

    // Byte class codes
    typedef logic [2:0] t_cls;
    localparam t_cls CLS_PLAIN   = 3'd0;
    localparam t_cls CLS_NULL    = 3'd1;
    localparam t_cls CLS_CONTROL = 3'd2;
    localparam t_cls CLS_VALID   = 3'd3;
    localparam t_cls CLS_INVALID = 3'd4;

    // Byte values of interest
    localparam logic [7:0] BYTE_NUL       = 8'h00;
    localparam logic [7:0] BYTE_CTRL_END  = 8'h20;
    localparam logic [7:0] BYTE_ASCII_MAX = 8'h7F;
    localparam logic [7:0] BYTE_LEAD2     = 8'hC2;
    localparam logic [7:0] BYTE_LEAD3     = 8'hE0;
    localparam logic [7:0] BYTE_LEAD4     = 8'hF0;
    localparam logic [7:0] BYTE_LEAD5     = 8'hF8;
    localparam logic [7:0] BYTE_LEAD6     = 8'hFC;
    localparam logic [7:0] BYTE_LEAD7     = 8'hFE;
    localparam logic [7:0] BYTE_ALL_ONES  = 8'hFF;
    localparam logic [7:0] CONT_MASK      = 8'hC0;
    localparam logic [7:0] CONT_TAG       = 8'h80;
    localparam logic [7:0] BYTE_NEWLINE   = 8'h0A;

    // Configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_HIGHLIGHT  = 2'd0;
    localparam t_cfg_idx CFG_BREAK_NL   = 2'd1;
    localparam t_cfg_idx CFG_LINE_BYTES = 2'd2;

    // Source of an emitted result
    typedef logic [1:0] t_src;
    localparam t_src SRC_PEND = 2'd0;
    localparam t_src SRC_BYTE = 2'd1;
    localparam t_src SRC_MARK = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic load;          // latch the incoming byte
        logic emit;          // write the result register
        t_src src;           // pending slot, latched byte or line-close marker
        t_cls cls;           // class for pending and completed bytes
        logic cls_from_byte; // classify latched byte as a fresh byte
        logic last;          // final result of this input word
        logic clear_pend;    // drop the sequence buffer
        logic store;         // append latched byte to the sequence buffer
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_eos;     // incoming word is end of stream
        logic pend_any;   // sequence buffer not empty
        logic in_cont;    // incoming byte is 10xxxxxx
        logic seq_done;   // one more continuation completes the sequence
        logic new_store;  // incoming byte would open a sequence
        logic flush_last; // flush index at last buffered byte
        logic out_free;   // result register can take a word
    } t_dp_status;

    // Expected sequence length from a lead byte, 0 when not a lead
    function automatic logic [LEN_W-1:0] lead_length(input logic [7:0] b);
        logic [LEN_W-1:0] len;
        if (b < BYTE_LEAD2)         len = 3'd0;
        else if (b < BYTE_LEAD3)    len = 3'd2;
        else if (b < BYTE_LEAD4)    len = 3'd3;
        else if (b < BYTE_LEAD5)    len = 3'd4;
        else if (b < BYTE_LEAD6)    len = 3'd5;
        else if (b < BYTE_LEAD7)    len = 3'd6;
        else if (b < BYTE_ALL_ONES) len = 3'd7;
        else                        len = 3'd0;
        return len;
    endfunction

    // Class of a fresh byte that is emitted on its own
    function automatic t_cls byte_class_new(input logic [7:0] b, input logic hl);
        t_cls c;
        if (b == BYTE_NUL)                   c = CLS_NULL;
        else if (hl && b < BYTE_CTRL_END)    c = CLS_CONTROL;
        else if (hl && b > BYTE_ASCII_MAX)   c = CLS_INVALID;
        else                                 c = CLS_PLAIN;
        return c;
    endfunction

endpackage

@@ src/hxu8c_ctrl.sv @@
module hxu8c_ctrl #(
    parameter int MAX_SEQUENCE = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  hxu8c_pkg::t_dp_status    i_status,
    output hxu8c_pkg::t_dp_cmd       o_cmd,
    output logic [$clog2(MAX_SEQUENCE-1)-1:0] o_idx
);
    import hxu8c_pkg::*;

    localparam int PEND_DEPTH = MAX_SEQUENCE - 1;
    localparam int IDX_W      = $clog2(PEND_DEPTH);

    // Controller states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FLUSH = 2'd1;
    localparam logic [1:0] S_TAIL  = 2'd2;

    // Action after the flush
    localparam logic [1:0] TK_EMIT_NEW   = 2'd0;
    localparam logic [1:0] TK_EMIT_VALID = 2'd1;
    localparam logic [1:0] TK_STORE      = 2'd2;
    localparam logic [1:0] TK_MARK       = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [1:0]       r_tail,  n_tail;
    t_cls             r_fcls,  n_fcls;
    logic [IDX_W-1:0] r_idx,   n_idx;
    t_dp_cmd          w_cmd;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_tail  = r_tail;
        n_fcls  = r_fcls;
        n_idx   = r_idx;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_idx      = '0;
                    if (i_status.in_eos) begin
                        n_fcls  = CLS_INVALID;
                        n_tail  = TK_MARK;
                        n_state = i_status.pend_any ? S_FLUSH : S_TAIL;
                    end else if (i_status.pend_any && i_status.in_cont) begin
                        if (i_status.seq_done) begin
                            n_fcls  = CLS_VALID;
                            n_tail  = TK_EMIT_VALID;
                            n_state = S_FLUSH;
                        end else begin
                            n_tail  = TK_STORE;
                            n_state = S_TAIL;
                        end
                    end else begin
                        n_fcls  = CLS_INVALID;
                        n_tail  = i_status.new_store ? TK_STORE : TK_EMIT_NEW;
                        n_state = i_status.pend_any ? S_FLUSH : S_TAIL;
                    end
                end
            end
            S_FLUSH: begin
                if (i_status.out_free) begin
                    w_cmd.emit = 1'b1;
                    w_cmd.src  = SRC_PEND;
                    w_cmd.cls  = r_fcls;
                    w_cmd.last = i_status.flush_last && (r_tail == TK_STORE);
                    if (i_status.flush_last) begin
                        w_cmd.clear_pend = 1'b1;
                        n_state          = S_TAIL;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_TAIL: begin
                unique case (r_tail)
                    TK_STORE: begin
                        w_cmd.store = 1'b1;
                        n_state     = S_IDLE;
                    end
                    TK_MARK: begin
                        if (i_status.out_free) begin
                            w_cmd.emit = 1'b1;
                            w_cmd.src  = SRC_MARK;
                            w_cmd.cls  = CLS_PLAIN;
                            w_cmd.last = 1'b1;
                            n_state    = S_IDLE;
                        end
                    end
                    TK_EMIT_VALID: begin
                        if (i_status.out_free) begin
                            w_cmd.emit = 1'b1;
                            w_cmd.src  = SRC_BYTE;
                            w_cmd.cls  = CLS_VALID;
                            w_cmd.last = 1'b1;
                            n_state    = S_IDLE;
                        end
                    end
                    default: begin
                        if (i_status.out_free) begin
                            w_cmd.emit          = 1'b1;
                            w_cmd.src           = SRC_BYTE;
                            w_cmd.cls_from_byte = 1'b1;
                            w_cmd.last          = 1'b1;
                            n_state             = S_IDLE;
                        end
                    end
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tail  <= TK_EMIT_NEW;
            r_fcls  <= CLS_PLAIN;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_tail  <= n_tail;
            r_fcls  <= n_fcls;
            r_idx   <= n_idx;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = w_cmd;
    assign o_idx      = r_idx;

endmodule

@@ src/hxu8c_dp.sv @@
module hxu8c_dp #(
    parameter int MAX_SEQUENCE   = 7,
    parameter int MAX_LINE_BYTES = 1024,
    parameter int OFFSET_BITS    = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration writes
    input  logic                     i_cfg_we,
    input  hxu8c_pkg::t_cfg_idx      i_cfg_index,
    input  logic [hxu8c_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // incoming word
    input  logic [7:0]               i_in_byte,
    input  logic                     i_in_eos,
    // controller link
    input  hxu8c_pkg::t_dp_cmd       i_cmd,
    input  logic [$clog2(MAX_SEQUENCE-1)-1:0] i_idx,
    output hxu8c_pkg::t_dp_status    o_status,
    // result register
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic [7:0]               o_out_byte,
    output logic                     o_out_has_byte,
    output hxu8c_pkg::t_cls          o_out_class,
    output logic [hxu8c_pkg::OFF_OUT_W-1:0] o_out_offset,
    output logic [hxu8c_pkg::COL_OUT_W-1:0] o_out_column,
    output logic                     o_out_line_start,
    output logic                     o_out_line_end,
    output logic                     o_out_last
);
    import hxu8c_pkg::*;

    localparam int PEND_DEPTH = MAX_SEQUENCE - 1;
    localparam int IDX_W      = $clog2(PEND_DEPTH);
    localparam int CNT_W      = $clog2(PEND_DEPTH + 1);
    localparam int COL_W      = $clog2(MAX_LINE_BYTES);
    localparam int BPL_W      = $clog2(MAX_LINE_BYTES + 1);
    localparam int BPL_RESET  = (MAX_LINE_BYTES < 16) ? MAX_LINE_BYTES : 16;

    // Configuration
    logic             r_hl;
    logic             r_bon;
    logic [BPL_W-1:0] r_bpl;

    // Sequence buffer and position
    logic [7:0]             r_pend [PEND_DEPTH];
    logic [CNT_W-1:0]       r_cnt;
    logic [LEN_W-1:0]       r_exp;
    logic [OFFSET_BITS-1:0] r_off;
    logic [COL_W-1:0]       r_col;
    logic [7:0]             r_in_byte;

    // Result register
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_out_has;
    t_cls                 r_out_cls;
    logic [OFF_OUT_W-1:0] r_out_off;
    logic [COL_OUT_W-1:0] r_out_col;
    logic                 r_out_ls;
    logic                 r_out_le;
    logic                 r_out_last;

    logic [CFG_DATA_W-1:0] w_bpl_sat;
    logic [LEN_W-1:0]      w_in_len;
    logic                  w_out_free;
    logic [7:0]            w_byte;
    t_cls                  w_cls;
    logic [BPL_W-1:0]      w_col_inc;
    logic                  w_le;
    logic                  w_ls;
    logic [63:0]           w_off_ext;

    // Line length saturates to the legal range
    always_comb begin
        if (i_cfg_data < CFG_DATA_W'(2))
            w_bpl_sat = CFG_DATA_W'(2);
        else if (i_cfg_data > CFG_DATA_W'(MAX_LINE_BYTES))
            w_bpl_sat = CFG_DATA_W'(MAX_LINE_BYTES);
        else
            w_bpl_sat = i_cfg_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hl  <= 1'b0;
            r_bon <= 1'b0;
            r_bpl <= BPL_W'(BPL_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HIGHLIGHT:  r_hl  <= i_cfg_data[0];
                CFG_BREAK_NL:   r_bon <= i_cfg_data[0];
                CFG_LINE_BYTES: r_bpl <= BPL_W'(w_bpl_sat);
                default: ;
            endcase
        end
    end

    // Status toward the controller
    assign w_in_len   = lead_length(i_in_byte);
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_status            = '0;
        o_status.in_eos     = i_in_eos;
        o_status.pend_any   = (r_cnt != '0);
        o_status.in_cont    = ((i_in_byte & CONT_MASK) == CONT_TAG);
        o_status.seq_done   = ((4'(r_cnt) + 4'd1) >= 4'(r_exp))
                              || (r_cnt >= CNT_W'(PEND_DEPTH));
        o_status.new_store  = r_hl && (i_in_byte > BYTE_ASCII_MAX)
                              && (w_in_len != '0)
                              && (w_in_len <= LEN_W'(MAX_SEQUENCE));
        o_status.flush_last = (i_idx == IDX_W'(r_cnt - CNT_W'(1)));
        o_status.out_free   = w_out_free;
    end

    // Byte and class of the result being formed
    always_comb begin
        case (i_cmd.src)
            SRC_PEND: w_byte = r_pend[i_idx];
            SRC_BYTE: w_byte = r_in_byte;
            default:  w_byte = BYTE_NUL;
        endcase
        if (i_cmd.src == SRC_MARK)
            w_cls = CLS_PLAIN;
        else if (i_cmd.cls_from_byte)
            w_cls = byte_class_new(r_in_byte, r_hl);
        else
            w_cls = i_cmd.cls;
    end

    // Line flags
    assign w_col_inc = BPL_W'(r_col) + BPL_W'(1);
    always_comb begin
        if (i_cmd.src == SRC_MARK) begin
            w_ls = 1'b0;
            w_le = (r_col != '0);
        end else begin
            w_ls = (r_col == '0);
            w_le = (w_col_inc >= r_bpl) || (r_bon && (w_byte == BYTE_NEWLINE));
        end
    end

    assign w_off_ext = 64'(r_off);

    // Input latch and sequence buffer contents
    always_ff @(posedge i_clk) begin
        if (i_cmd.load)
            r_in_byte <= i_in_byte;
        if (i_cmd.store)
            r_pend[r_cnt[IDX_W-1:0]] <= r_in_byte;
    end

    // Sequence fill and length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_exp <= '0;
        end else if (i_cmd.clear_pend) begin
            r_cnt <= '0;
            r_exp <= '0;
        end else if (i_cmd.store) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == '0)
                r_exp <= lead_length(r_in_byte);
        end
    end

    // Offset and column advance on every emitted byte; the line-close marker only resets the column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= '0;
            r_col <= '0;
        end else if (i_cmd.emit) begin
            if (i_cmd.src == SRC_MARK) begin
                r_col <= '0;
            end else begin
                r_off <= r_off + OFFSET_BITS'(1);
                r_col <= w_le ? '0 : w_col_inc[COL_W-1:0];
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte <= w_byte;
            r_out_has  <= (i_cmd.src != SRC_MARK);
            r_out_cls  <= w_cls;
            r_out_off  <= w_off_ext[OFF_OUT_W-1:0];
            r_out_col  <= COL_OUT_W'(r_col);
            r_out_ls   <= w_ls;
            r_out_le   <= w_le;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_out_has_byte   = r_out_has;
    assign o_out_class      = r_out_cls;
    assign o_out_offset     = r_out_off;
    assign o_out_column     = r_out_col;
    assign o_out_line_start = r_out_ls;
    assign o_out_line_end   = r_out_le;
    assign o_out_last       = r_out_last;

endmodule

@@ src/hexdump_utf8_byte_classifier_unit.sv @@
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: data_byte; tlast: end_of_stream
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: byte, offset, column, line flags;
//                                               tuser: has_byte, byte_class; tlast: last
// cfg       in   i_cfg_valid/o_cfg_ready        i_cfg_index, i_cfg_data
//
// An input word is accepted, then each buffered byte is flushed
// (0 .. MAX_SEQUENCE-1 of them), then the closing action runs.
// Every result passes through the single output register, at most one word per cycle while m_axis is not stalled.
// A stall on m_axis holds the flush/close sequencer; the input stays blocked
// until the sequence for the current word is done.
// Synchronous active-low reset; configuration writes are taken every cycle.
module hexdump_utf8_byte_classifier_unit #(
    parameter int MAX_SEQUENCE   = 7,
    parameter int MAX_LINE_BYTES = 1024,
    parameter int OFFSET_BITS    = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  hxu8c_pkg::t_cfg_idx i_cfg_index,
    input  logic [hxu8c_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tlast,  // end_of_stream
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // [7:0] out_byte, [39:8] byte_offset_out,
                                       // [49:40] column, [50] line_start,
                                       // [51] line_end, [55:52] zero
    output logic [3:0]  m_axis_tuser,  // [0] has_byte, [3:1] byte_class
    output logic        m_axis_tlast   // last
);
    import hxu8c_pkg::*;

    localparam int IDX_W = $clog2(MAX_SEQUENCE - 1);

    t_dp_cmd              w_cmd;
    t_dp_status           w_status;
    logic [IDX_W-1:0]     w_idx;
    logic [7:0]           w_out_byte;
    logic                 w_out_has;
    t_cls                 w_out_cls;
    logic [OFF_OUT_W-1:0] w_out_off;
    logic [COL_OUT_W-1:0] w_out_col;
    logic                 w_out_ls;
    logic                 w_out_le;

    assign o_cfg_ready = 1'b1;

    hxu8c_ctrl #(
        .MAX_SEQUENCE (MAX_SEQUENCE)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx)
    );

    hxu8c_dp #(
        .MAX_SEQUENCE   (MAX_SEQUENCE),
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .OFFSET_BITS    (OFFSET_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_byte        (s_axis_tdata),
        .i_in_eos         (s_axis_tlast),
        .i_cmd            (w_cmd),
        .i_idx            (w_idx),
        .o_status         (w_status),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_out_byte       (w_out_byte),
        .o_out_has_byte   (w_out_has),
        .o_out_class      (w_out_cls),
        .o_out_offset     (w_out_off),
        .o_out_column     (w_out_col),
        .o_out_line_start (w_out_ls),
        .o_out_line_end   (w_out_le),
        .o_out_last       (m_axis_tlast)
    );

    // Pack result fields
    assign m_axis_tdata = {4'b0000, w_out_le, w_out_ls, w_out_col, w_out_off, w_out_byte};
    assign m_axis_tuser = {w_out_cls, w_out_has};

    // Never overwrite a result that has not been taken
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_status.out_free)
        else $error("result register overwritten");

    // No input is taken while results of the previous word are produced
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> !s_axis_tready)
        else $error("input accepted during emission");

    // The line-close marker is always the final result of its word
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !w_out_has) |-> m_axis_tlast)
        else $error("marker not last");

    // A line opens only at column zero
    a_start_col0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_out_ls) |-> (w_out_col == '0))
        else $error("line start off column zero");

endmodule
